// ===== hw/rtl/ycnf_pkg.sv =====
// Shared types, constants and arithmetic helpers of the yaw complementary navigation filter.
package ycnf_pkg;

    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 17;
    localparam int STEP_W     = 16;
    localparam int YAW_W      = 20;
    localparam int HEAD_W     = 19;
    localparam int QUAT_W     = 18;
    localparam int ANG_W      = 36;
    localparam int REM_W      = 37;
    localparam int Z_W        = 35;
    localparam int XY_W       = 64;
    localparam int MA_W       = 36;
    localparam int MB_W       = 19;
    localparam int PROD_W     = 56;
    localparam int WIDE_W     = 40;
    localparam int TRIG_W     = 19;
    localparam int FQ_W       = 50;
    localparam int CFG_IDX_W  = 2;
    localparam int ATAN_IDX_W = 5;
    localparam int VEC_SHIFT  = 29;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;
    localparam int WSTEP_W    = 5;

    // Highest shift of 2*pi used by the angle reduction (covers magnitudes below 2^35).
    localparam logic [WSTEP_W-1:0] WRAP_TOP = 5'd16;

    localparam logic signed [ANG_W-1:0] PI_FIX      = 36'sd205887;
    localparam logic [REM_W-1:0]        TWO_PI_U    = 37'd411774;
    localparam logic signed [DATA_W-1:0] EPS_VEL    = 32'sd66;
    localparam logic signed [Z_W-1:0]   PI_Q30      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0]   HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam logic [GAIN_W-1:0]       GAIN_RESET  = 17'd6554;
    localparam logic signed [MB_W-1:0]  GAIN_ONE    = 19'sd65536;

    localparam logic [1:0] OP_IMU  = 2'd0;
    localparam logic [1:0] OP_GPS  = 2'd1;
    localparam logic [1:0] OP_BARO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_POS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_VEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_HEAD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ALT  = 2'd3;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_IMU,
        CLS_GPS,
        CLS_BARO
    } cls_t;

    typedef struct packed {
        cls_t                     cls;
        logic [STEP_W-1:0]        step_time;
        logic signed [DATA_W-1:0] meas_a;
        logic signed [DATA_W-1:0] meas_b;
        logic signed [DATA_W-1:0] meas_c;
        logic signed [DATA_W-1:0] meas_d;
        logic signed [DATA_W-1:0] meas_e;
        logic signed [DATA_W-1:0] meas_f;
    } item_t;

    typedef struct packed {
        logic [GAIN_W-1:0] pos;
        logic [GAIN_W-1:0] vel;
        logic [GAIN_W-1:0] head;
        logic [GAIN_W-1:0] alt;
    } gains_t;

    typedef struct packed {
        logic                     start;
        logic                     vector;
        logic signed [Z_W-1:0]    z;
        logic signed [DATA_W-1:0] xv;
        logic signed [DATA_W-1:0] yv;
    } cordic_req_t;

    typedef struct packed {
        logic                   done;
        logic                   busy;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_res_t;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [30:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:    v = 31'd843314856;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043836;
            5'd3:    v = 31'd133525158;
            5'd4:    v = 31'd67021686;
            5'd5:    v = 31'd33543515;
            5'd6:    v = 31'd16775850;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194282;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048575;
            5'd11:   v = 31'd524287;
            5'd12:   v = 31'd262143;
            5'd13:   v = 31'd131071;
            5'd14:   v = 31'd65535;
            5'd15:   v = 31'd32767;
            5'd16:   v = 31'd16383;
            5'd17:   v = 31'd8191;
            5'd18:   v = 31'd4095;
            5'd19:   v = 31'd2047;
            5'd20:   v = 31'd1023;
            5'd21:   v = 31'd511;
            5'd22:   v = 31'd255;
            5'd23:   v = 31'd127;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    // Product scaled down by 2^16 with round half up.
    function automatic logic signed [WIDE_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + $signed({{(PROD_W-17){1'b0}}, 17'h08000});
        return t[PROD_W-1:16];
    endfunction

    // Q30 value brought to Q16 with round half up.
    function automatic logic signed [FQ_W-1:0] fq30(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] t;
        t = v + 64'sd8192;
        return t[XY_W-1:14];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ycnf_front.sv =====
// Front end: input acceptance, event classification, gain registers and the item queue.
module ycnf_front import ycnf_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic [1:0]               op,
    input  logic                     meas_valid,
    input  logic [STEP_W-1:0]        step_time,
    input  logic signed [DATA_W-1:0] meas_a,
    input  logic signed [DATA_W-1:0] meas_b,
    input  logic signed [DATA_W-1:0] meas_c,
    input  logic signed [DATA_W-1:0] meas_d,
    input  logic signed [DATA_W-1:0] meas_e,
    input  logic signed [DATA_W-1:0] meas_f,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [GAIN_W-1:0]        cfg_data,
    output gains_t                   gains,
    output logic                     q_valid,
    input  logic                     q_pop,
    output item_t                    q_item
);

    item_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg;
    logic [Q_CNT_W-1:0]  count_next;
    gains_t              gains_reg;
    item_t               new_item;
    logic                push;

    // Events that leave the state alone are still queued: they produce a result too.
    always_comb
    begin
        new_item.step_time = step_time;
        new_item.meas_a    = meas_a;
        new_item.meas_b    = meas_b;
        new_item.meas_c    = meas_c;
        new_item.meas_d    = meas_d;
        new_item.meas_e    = meas_e;
        new_item.meas_f    = meas_f;
        case (op)
            OP_IMU:  new_item.cls = (step_time != '0) ? CLS_IMU : CLS_NONE;
            OP_GPS:  new_item.cls = meas_valid ? CLS_GPS : CLS_NONE;
            OP_BARO: new_item.cls = meas_valid ? CLS_BARO : CLS_NONE;
            default: new_item.cls = CLS_NONE;
        endcase
    end

    assign item_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign push       = item_valid && item_ready;
    assign q_valid    = (count_reg != '0);
    assign q_item     = mem_reg[rd_ptr_reg];
    assign cfg_ready  = 1'b1;
    assign gains      = gains_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            gains_reg  <= '{GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET};
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_GAIN_POS:  gains_reg.pos  <= cfg_data;
                    CFG_GAIN_VEL:  gains_reg.vel  <= cfg_data;
                    CFG_GAIN_HEAD: gains_reg.head <= cfg_data;
                    CFG_GAIN_ALT:  gains_reg.alt  <= cfg_data;
                    default:       gains_reg      <= gains_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (count_reg != '0))
        else $error("queue popped while empty");
`endif

endmodule

// ===== hw/rtl/ycnf_cordic.sv =====
// Shared iterative CORDIC unit: rotation for sine and cosine, vectoring for the track angle.
module ycnf_cordic import ycnf_pkg::*; #(
    parameter int ITER = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cordic_req_t req,
    output cordic_res_t res
);

    localparam int IW = $clog2(ITER);
    localparam logic [IW-1:0] LAST = IW'(ITER - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [IW-1:0]          iter_reg;
    logic                   vec_reg;
    logic                   flip_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;

    logic signed [XY_W-1:0] x_init;
    logic signed [XY_W-1:0] y_init;
    logic signed [Z_W-1:0]  z_init;
    logic                   flip_init;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [XY_W-1:0] x_sh;
    logic signed [XY_W-1:0] y_sh;
    logic signed [Z_W-1:0]  at;
    logic                   ccw;

    // Operand preparation: quadrant fold for rotation, half-plane fold for vectoring.
    always_comb
    begin
        xs        = XY_W'(req.xv) <<< VEC_SHIFT;
        ys        = XY_W'(req.yv) <<< VEC_SHIFT;
        x_init    = CORDIC_GAIN_Q30;
        y_init    = '0;
        z_init    = req.z;
        flip_init = 1'b0;
        if (req.vector) begin
            z_init = '0;
            x_init = xs;
            y_init = ys;
            if (xs < 0) begin
                z_init = (ys >= 0) ? PI_Q30 : -PI_Q30;
                x_init = -xs;
                y_init = -ys;
            end
        end else if (req.z > HALF_PI_Q30) begin
            z_init    = req.z - PI_Q30;
            flip_init = 1'b1;
        end else if (req.z < -HALF_PI_Q30) begin
            z_init    = req.z + PI_Q30;
            flip_init = 1'b1;
        end
    end

    always_comb
    begin
        x_sh = x_reg >>> iter_reg;
        y_sh = y_reg >>> iter_reg;
        at   = Z_W'(atan_q30(ATAN_IDX_W'(iter_reg)));
        ccw  = vec_reg ? (y_reg <= 0) : (z_reg >= 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end else if (busy_reg) begin
                if (iter_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start) begin
            x_reg    <= x_init;
            y_reg    <= y_init;
            z_reg    <= z_init;
            flip_reg <= flip_init;
            vec_reg  <= req.vector;
        end else if (busy_reg) begin
            if (ccw) begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + at;
            end
        end
    end

    assign res.done = done_reg;
    assign res.busy = busy_reg;
    assign res.x    = flip_reg ? -x_reg : x_reg;
    assign res.y    = flip_reg ? -y_reg : y_reg;
    assign res.z    = z_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("CORDIC started while busy");
`endif

endmodule

// ===== hw/rtl/ycnf_back.sv =====
// Back end: sequencer and shared multiplier that update the state and build each result.
module ycnf_back import ycnf_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  item_t                    q_item,
    output logic                     q_pop,
    input  gains_t                   gains,
    output cordic_req_t              cordic_req,
    input  cordic_res_t              cordic_res,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic signed [DATA_W-1:0] pos_north,
    output logic signed [DATA_W-1:0] pos_east,
    output logic signed [DATA_W-1:0] pos_down,
    output logic signed [DATA_W-1:0] vel_north,
    output logic signed [DATA_W-1:0] vel_east,
    output logic signed [DATA_W-1:0] vel_down,
    output logic signed [HEAD_W-1:0] heading,
    output logic signed [QUAT_W-1:0] quat_scalar,
    output logic signed [QUAT_W-1:0] quat_z,
    output logic                     is_initialised
);

    typedef enum logic [5:0] {
        S_IDLE, S_DISP,
        S_I0, S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_I7, S_I8, S_I9, S_I10, S_I11,
        S_GI0, S_G0, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6,
        S_VEC, S_VECW, S_GI_SET, S_G_ERR, S_G10, S_G11, S_G12,
        S_B0, S_B1, S_B2,
        S_WCHK, S_WRED, S_WFIN,
        S_QSTART, S_QWAIT, S_QOUT
    } state_t;

    state_t                   state_reg;
    state_t                   ret_reg;
    item_t                    item_reg;
    logic signed [DATA_W-1:0] pos_reg [3];
    logic signed [DATA_W-1:0] vel_reg [3];
    logic signed [YAW_W-1:0]  yaw_reg;
    logic                     init_reg;
    logic                     first_reg;
    logic signed [ANG_W-1:0]  ang_reg;
    logic [REM_W-1:0]         rem_reg;
    logic                     neg_reg;
    logic                     above_reg;
    logic [WSTEP_W-1:0]       wstep_reg;
    logic signed [TRIG_W-1:0] cf_reg;
    logic signed [TRIG_W-1:0] sf_reg;
    logic signed [MA_W-1:0]   an_reg;
    logic signed [MA_W-1:0]   ae_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] mul_reg;
    logic                     res_valid_reg;
    logic signed [DATA_W-1:0] out_pos_reg [3];
    logic signed [DATA_W-1:0] out_vel_reg [3];
    logic signed [HEAD_W-1:0] out_head_reg;
    logic signed [QUAT_W-1:0] out_qs_reg;
    logic signed [QUAT_W-1:0] out_qz_reg;
    logic                     out_init_reg;

    logic signed [MA_W-1:0]       mul_a;
    logic signed [MB_W-1:0]       mul_b;
    logic signed [MA_W+MB_W-1:0]  prod;
    logic signed [WIDE_W-1:0]     rp;
    logic signed [MB_W-1:0]       dt_b;
    logic signed [ANG_W:0]        wv;
    logic [REM_W-1:0]             wshift;
    logic [REM_W-1:0]             wmod;
    logic signed [ANG_W-1:0]      wres;
    logic                         moving;
    logic                         out_free;

    assign dt_b     = $signed({3'b000, item_reg.step_time});
    assign rp       = rnd16(mul_reg);
    assign prod     = mul_a * mul_b;
    assign out_free = !res_valid_reg || result_ready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign moving   = (item_reg.meas_d > EPS_VEL) || (item_reg.meas_d < -EPS_VEL) ||
                      (item_reg.meas_e > EPS_VEL) || (item_reg.meas_e < -EPS_VEL);

    // Angle reduction helpers: the residue of (angle + pi) modulo 2*pi, taken on the magnitude.
    always_comb
    begin
        wv     = (ANG_W+1)'(ang_reg) + (ANG_W+1)'(PI_FIX);
        wshift = TWO_PI_U << wstep_reg;
        wmod   = (neg_reg && (rem_reg != '0)) ? (TWO_PI_U - rem_reg) : rem_reg;
        wres   = $signed(ANG_W'(wmod)) - PI_FIX;
        if (above_reg && (wres == -PI_FIX)) begin
            wres = PI_FIX;
        end
    end

    // Operands of the shared multiplier; its product is consumed one state later.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_I0:  begin mul_a = MA_W'(item_reg.meas_a); mul_b = dt_b; end
            S_I4:  begin mul_a = MA_W'(item_reg.meas_b); mul_b = cf_reg; end
            S_I5:  begin mul_a = MA_W'(item_reg.meas_b); mul_b = sf_reg; end
            S_I6:  begin mul_a = an_reg; mul_b = dt_b; end
            S_I7:  begin mul_a = ae_reg; mul_b = dt_b; end
            S_I8:  begin mul_a = MA_W'(vel_reg[0]); mul_b = dt_b; end
            S_I9:  begin mul_a = MA_W'(vel_reg[1]); mul_b = dt_b; end
            S_I10: begin mul_a = MA_W'(vel_reg[2]); mul_b = dt_b; end
            S_G0:  begin
                mul_a = MA_W'(item_reg.meas_a) - MA_W'(pos_reg[0]);
                mul_b = $signed({2'b00, gains.pos});
            end
            S_G1:  begin
                mul_a = MA_W'(item_reg.meas_b) - MA_W'(pos_reg[1]);
                mul_b = $signed({2'b00, gains.pos});
            end
            S_G2:  begin
                mul_a = MA_W'(item_reg.meas_c) - MA_W'(pos_reg[2]);
                mul_b = $signed({2'b00, gains.pos});
            end
            S_G3:  begin
                mul_a = MA_W'(item_reg.meas_d) - MA_W'(vel_reg[0]);
                mul_b = $signed({2'b00, gains.vel});
            end
            S_G4:  begin
                mul_a = MA_W'(item_reg.meas_e) - MA_W'(vel_reg[1]);
                mul_b = $signed({2'b00, gains.vel});
            end
            S_G5:  begin
                mul_a = MA_W'(item_reg.meas_f) - MA_W'(vel_reg[2]);
                mul_b = $signed({2'b00, gains.vel});
            end
            S_G10: begin mul_a = ang_reg; mul_b = $signed({2'b00, gains.head}); end
            S_B0:  begin
                mul_a = MA_W'(pos_reg[2]);
                mul_b = GAIN_ONE - $signed({2'b00, gains.alt});
            end
            S_B1:  begin
                mul_a = MA_W'(0) - MA_W'(item_reg.meas_a);
                mul_b = $signed({2'b00, gains.alt});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        cordic_req.start  = (state_reg == S_I2) || (state_reg == S_VEC) ||
                            (state_reg == S_QSTART);
        cordic_req.vector = (state_reg == S_VEC);
        cordic_req.xv     = item_reg.meas_d;
        cordic_req.yv     = item_reg.meas_e;
        if (state_reg == S_I2) begin
            cordic_req.z = Z_W'(ang_reg) <<< 14;
        end else begin
            cordic_req.z = Z_W'(yaw_reg) <<< 13;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= PROD_W'(prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            pos_reg       <= '{default: '0};
            vel_reg       <= '{default: '0};
            yaw_reg       <= '0;
            init_reg      <= 1'b0;
            first_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_valid_reg && result_ready && (state_reg != S_QOUT)) begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg  <= q_item;
                        state_reg <= S_DISP;
                    end
                end
                S_DISP: begin
                    case (item_reg.cls)
                        CLS_IMU:  state_reg <= init_reg ? S_I0 : S_QSTART;
                        CLS_GPS:  state_reg <= init_reg ? S_G0 : S_GI0;
                        CLS_BARO: state_reg <= S_B0;
                        default:  state_reg <= S_QSTART;
                    endcase
                end
                // IMU predict: yaw, then acceleration rotated by yaw, then velocity and position.
                S_I0: state_reg <= S_I1;
                S_I1: begin
                    ang_reg   <= ANG_W'(yaw_reg) + ANG_W'(rp);
                    ret_reg   <= S_I2;
                    state_reg <= S_WCHK;
                end
                S_I2: begin
                    yaw_reg   <= YAW_W'(ang_reg);
                    state_reg <= S_I3;
                end
                S_I3: begin
                    if (cordic_res.done) begin
                        cf_reg    <= TRIG_W'(fq30(cordic_res.x));
                        sf_reg    <= TRIG_W'(fq30(cordic_res.y));
                        state_reg <= S_I4;
                    end
                end
                S_I4: state_reg <= S_I5;
                S_I5: begin
                    an_reg    <= MA_W'(rp);
                    state_reg <= S_I6;
                end
                S_I6: begin
                    ae_reg    <= MA_W'(rp);
                    state_reg <= S_I7;
                end
                S_I7: begin
                    vel_reg[0] <= sat32(WIDE_W'(vel_reg[0]) + rp);
                    state_reg  <= S_I8;
                end
                S_I8: begin
                    vel_reg[1] <= sat32(WIDE_W'(vel_reg[1]) + rp);
                    state_reg  <= S_I9;
                end
                S_I9: begin
                    pos_reg[0] <= sat32(WIDE_W'(pos_reg[0]) + rp);
                    state_reg  <= S_I10;
                end
                S_I10: begin
                    pos_reg[1] <= sat32(WIDE_W'(pos_reg[1]) + rp);
                    state_reg  <= S_I11;
                end
                S_I11: begin
                    pos_reg[2] <= sat32(WIDE_W'(pos_reg[2]) + rp);
                    state_reg  <= S_QSTART;
                end
                // First GPS fix loads the state directly.
                S_GI0: begin
                    pos_reg[0] <= item_reg.meas_a;
                    pos_reg[1] <= item_reg.meas_b;
                    pos_reg[2] <= item_reg.meas_c;
                    vel_reg[0] <= item_reg.meas_d;
                    vel_reg[1] <= item_reg.meas_e;
                    vel_reg[2] <= item_reg.meas_f;
                    init_reg   <= 1'b1;
                    first_reg  <= 1'b1;
                    if (moving) begin
                        state_reg <= S_VEC;
                    end else begin
                        yaw_reg   <= '0;
                        state_reg <= S_QSTART;
                    end
                end
                S_G0: begin
                    first_reg <= 1'b0;
                    state_reg <= S_G1;
                end
                S_G1: begin
                    pos_reg[0] <= sat32(WIDE_W'(pos_reg[0]) + rp);
                    state_reg  <= S_G2;
                end
                S_G2: begin
                    pos_reg[1] <= sat32(WIDE_W'(pos_reg[1]) + rp);
                    state_reg  <= S_G3;
                end
                S_G3: begin
                    pos_reg[2] <= sat32(WIDE_W'(pos_reg[2]) + rp);
                    state_reg  <= S_G4;
                end
                S_G4: begin
                    vel_reg[0] <= sat32(WIDE_W'(vel_reg[0]) + rp);
                    state_reg  <= S_G5;
                end
                S_G5: begin
                    vel_reg[1] <= sat32(WIDE_W'(vel_reg[1]) + rp);
                    state_reg  <= S_G6;
                end
                S_G6: begin
                    vel_reg[2] <= sat32(WIDE_W'(vel_reg[2]) + rp);
                    state_reg  <= moving ? S_VEC : S_QSTART;
                end
                S_VEC: state_reg <= S_VECW;
                S_VECW: begin
                    if (cordic_res.done) begin
                        ang_reg   <= ANG_W'(fq30(XY_W'(cordic_res.z)));
                        ret_reg   <= first_reg ? S_GI_SET : S_G_ERR;
                        state_reg <= S_WCHK;
                    end
                end
                S_GI_SET: begin
                    yaw_reg   <= YAW_W'(ang_reg);
                    state_reg <= S_QSTART;
                end
                S_G_ERR: begin
                    ang_reg   <= ang_reg - ANG_W'(yaw_reg);
                    ret_reg   <= S_G10;
                    state_reg <= S_WCHK;
                end
                S_G10: state_reg <= S_G11;
                S_G11: begin
                    ang_reg   <= ANG_W'(yaw_reg) + ANG_W'(rp);
                    ret_reg   <= S_G12;
                    state_reg <= S_WCHK;
                end
                S_G12: begin
                    yaw_reg   <= YAW_W'(ang_reg);
                    state_reg <= S_QSTART;
                end
                // Barometer: weighted mix of the down position and the negated altitude.
                S_B0: state_reg <= S_B1;
                S_B1: begin
                    acc_reg   <= mul_reg;
                    state_reg <= S_B2;
                end
                S_B2: begin
                    pos_reg[2] <= sat32(rnd16(acc_reg + mul_reg));
                    state_reg  <= S_QSTART;
                end
                // Angle wrap to plus minus pi, one conditional subtract of 2*pi<<k per cycle.
                S_WCHK: begin
                    if ((ang_reg > PI_FIX) || (ang_reg < -PI_FIX)) begin
                        neg_reg   <= wv[ANG_W];
                        rem_reg   <= wv[ANG_W] ? REM_W'(-wv) : REM_W'(wv);
                        above_reg <= (ang_reg > PI_FIX);
                        wstep_reg <= WRAP_TOP;
                        state_reg <= S_WRED;
                    end else begin
                        state_reg <= ret_reg;
                    end
                end
                S_WRED: begin
                    if (rem_reg >= wshift) begin
                        rem_reg <= rem_reg - wshift;
                    end
                    if (wstep_reg == '0) begin
                        state_reg <= S_WFIN;
                    end else begin
                        wstep_reg <= wstep_reg - 1'b1;
                    end
                end
                S_WFIN: begin
                    ang_reg   <= wres;
                    state_reg <= ret_reg;
                end
                // Quaternion from half the yaw, then the result register.
                S_QSTART: state_reg <= S_QWAIT;
                S_QWAIT: begin
                    if (cordic_res.done) begin
                        state_reg <= S_QOUT;
                    end
                end
                S_QOUT: begin
                    if (out_free) begin
                        out_pos_reg   <= pos_reg;
                        out_vel_reg   <= vel_reg;
                        out_head_reg  <= HEAD_W'(yaw_reg);
                        out_qs_reg    <= QUAT_W'(fq30(cordic_res.x));
                        out_qz_reg    <= QUAT_W'(fq30(cordic_res.y));
                        out_init_reg  <= init_reg;
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid   = res_valid_reg;
    assign pos_north      = out_pos_reg[0];
    assign pos_east       = out_pos_reg[1];
    assign pos_down       = out_pos_reg[2];
    assign vel_north      = out_vel_reg[0];
    assign vel_east       = out_vel_reg[1];
    assign vel_down       = out_vel_reg[2];
    assign heading        = out_head_reg;
    assign quat_scalar    = out_qs_reg;
    assign quat_z         = out_qz_reg;
    assign is_initialised = out_init_reg;

`ifndef NO_ASSERTIONS
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ((ANG_W'(out_head_reg) <= PI_FIX) &&
                           (ANG_W'(out_head_reg) >= -PI_FIX)))
        else $error("heading outside plus minus pi");
    a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |=> init_reg)
        else $error("initialised flag dropped");
`endif

endmodule

// ===== hw/rtl/yaw_complementary_nav_filter.sv =====
// Top level of the yaw complementary navigation filter: front end, back end and CORDIC unit.
//
//   Channel   Handshake                Contents
//   item      item_valid/item_ready    op, meas_valid, step_time, meas_a .. meas_f
//   result    result_valid/result_ready  position, velocity, heading, quaternion, init flag
//   cfg       cfg_valid/cfg_ready      cfg_index (0 position, 1 velocity, 2 heading,
//                                      3 altitude gain), cfg_data
//
// Each transaction on the item channel produces exactly one result transaction.
// The time per item depends on its kind: events that change nothing and barometer
// readings use the CORDIC unit once, an IMU step after initialisation twice, and a GPS
// fix up to twice. Every angle that leaves plus minus pi adds a pass of reduction states.
// The shared CORDIC unit and the single multiplier set these processing times.
// Reset restores all gains to 6554 and clears the estimate; no clearing pass is needed.
// A two-entry queue lets the front take new items while the back end works or while a
// finished result waits in the output register for result_ready.
module yaw_complementary_nav_filter import ycnf_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic [1:0]               op,
    input  logic                     meas_valid,
    input  logic [STEP_W-1:0]        step_time,
    input  logic signed [DATA_W-1:0] meas_a,
    input  logic signed [DATA_W-1:0] meas_b,
    input  logic signed [DATA_W-1:0] meas_c,
    input  logic signed [DATA_W-1:0] meas_d,
    input  logic signed [DATA_W-1:0] meas_e,
    input  logic signed [DATA_W-1:0] meas_f,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic signed [DATA_W-1:0] pos_north,
    output logic signed [DATA_W-1:0] pos_east,
    output logic signed [DATA_W-1:0] pos_down,
    output logic signed [DATA_W-1:0] vel_north,
    output logic signed [DATA_W-1:0] vel_east,
    output logic signed [DATA_W-1:0] vel_down,
    output logic signed [HEAD_W-1:0] heading,
    output logic signed [QUAT_W-1:0] quat_scalar,
    output logic signed [QUAT_W-1:0] quat_z,
    output logic                     is_initialised,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [GAIN_W-1:0]        cfg_data
);

    // Gains pass unsynchronized; user must ensure they are only written while the block idles.
    gains_t      gains;
    logic        q_valid;
    logic        q_pop;
    item_t       q_item;
    cordic_req_t cordic_req;
    cordic_res_t cordic_res;

    ycnf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .op         (op),
        .meas_valid (meas_valid),
        .step_time  (step_time),
        .meas_a     (meas_a),
        .meas_b     (meas_b),
        .meas_c     (meas_c),
        .meas_d     (meas_d),
        .meas_e     (meas_e),
        .meas_f     (meas_f),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .gains      (gains),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item)
    );

    // One CORDIC serves the IMU rotation, the GPS track angle and the quaternion.
    ycnf_cordic #(
        .ITER (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .res   (cordic_res)
    );

    ycnf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .gains          (gains),
        .cordic_req     (cordic_req),
        .cordic_res     (cordic_res),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .pos_north      (pos_north),
        .pos_east       (pos_east),
        .pos_down       (pos_down),
        .vel_north      (vel_north),
        .vel_east       (vel_east),
        .vel_down       (vel_down),
        .heading        (heading),
        .quat_scalar    (quat_scalar),
        .quat_z         (quat_z),
        .is_initialised (is_initialised)
    );

endmodule

// ===== verif/tb_yaw_complementary_nav_filter.sv =====
// Self-checking testbench for the yaw complementary navigation filter top level.
`timescale 1ns / 100ps

module tb_yaw_complementary_nav_filter;
    import ycnf_pkg::*;

    // Fixed-point constants of the filter, kept here in 64-bit form for the predictor.
    localparam longint PI_Q30_L   = 64'sd3373259426;
    localparam longint HALF_PI_L  = 64'sd1686629713;
    localparam longint KGAIN_Q30  = 64'sd652032874;
    localparam longint PI_F       = 64'sd205887;
    localparam longint TWO_PI_F   = 64'sd411774;
    localparam longint STILL_VEL  = 64'sd66;
    localparam longint UNITY_GAIN = 64'sd65536;
    localparam int     ROT_STEPS  = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One sensor event as driven on the item channel.
    typedef struct {
        logic [1:0]               kind;
        logic                     valid_flag;
        logic [STEP_W-1:0]        dt;
        logic signed [DATA_W-1:0] ma, mb, mc, md, me, mf;
    } sensor_event_t;

    // One navigation state report as seen on the result channel.
    typedef struct {
        logic signed [DATA_W-1:0] pn, pe, pd, vn, ve, vd;
        logic [HEAD_W-1:0]        hd;
        logic [QUAT_W-1:0]        qs, qz;
        logic                     init;
    } nav_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    logic [1:0] op = '0;
    logic meas_valid = 1'b0;
    logic [STEP_W-1:0] step_time = '0;
    logic signed [DATA_W-1:0] meas_a = '0, meas_b = '0, meas_c = '0;
    logic signed [DATA_W-1:0] meas_d = '0, meas_e = '0, meas_f = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic signed [DATA_W-1:0] pos_north, pos_east, pos_down, vel_north, vel_east, vel_down;
    logic signed [HEAD_W-1:0] heading;
    logic signed [QUAT_W-1:0] quat_scalar, quat_z;
    logic is_initialised;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAIN_W-1:0] cfg_data = '0;

    // Events waiting to be driven, and reports that the filter still owes us.
    sensor_event_t event_fifo[$];
    nav_report_t   report_fifo[$];
    sensor_event_t on_bus;
    bit            bus_taken = 1'b0;
    bit            failed = 1'b0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    // Predictor copy of the filter state and gains.
    longint nav_pos[3], nav_vel[3], nav_yaw;
    bit     nav_init;
    longint k_pos, k_vel, k_head, k_alt;
    longint atan_tab[24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127};

    yaw_complementary_nav_filter uut (.*);

    always #6 clk = ~clk;

    // Arithmetic shift right with round half up.
    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Brings an angle back into plus minus pi by whole turns.
    function automatic longint wrap_pi(longint a);
        longint k;
        if (a > PI_F) begin
            k = (a - PI_F + TWO_PI_F - 1) / TWO_PI_F;
            a -= k * TWO_PI_F;
        end else if (a < -PI_F) begin
            k = (-PI_F - a + TWO_PI_F - 1) / TWO_PI_F;
            a += k * TWO_PI_F;
        end
        return a;
    endfunction

    // Rotation-mode CORDIC on a Q30 angle; a half turn is folded out first.
    function automatic void rotate_q30(longint z, output longint c, output longint s);
        longint x, y, xn;
        bit flip;
        x = KGAIN_Q30;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI_L) begin
            z -= PI_Q30_L;
            flip = 1'b1;
        end else if (z < -HALF_PI_L) begin
            z += PI_Q30_L;
            flip = 1'b1;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            if (z >= 0) begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_tab[i];
            end else begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_tab[i];
            end
            x = xn;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Vectoring-mode CORDIC: track angle of a velocity, in Q16 radians, wrapped.
    function automatic longint track_of(longint vn, longint ve);
        longint x, y, z, xn;
        x = vn <<< 29;
        y = ve <<< 29;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q30_L : -PI_Q30_L;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            if (y > 0) begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_tab[i];
            end else begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_tab[i];
            end
            x = xn;
        end
        return wrap_pi(round_shift(z, 14));
    endfunction

    function automatic bit is_moving(longint vn, longint ve);
        return (vn > STILL_VEL || -vn > STILL_VEL || ve > STILL_VEL || -ve > STILL_VEL);
    endfunction

    // Advances the predicted state by one event and returns the report it should produce.
    function automatic nav_report_t advance_nav(sensor_event_t ev);
        nav_report_t r;
        longint m[6];
        longint dt, c, s, an, ae, err;
        m = '{longint'(ev.ma), longint'(ev.mb), longint'(ev.mc),
              longint'(ev.md), longint'(ev.me), longint'(ev.mf)};
        dt = longint'(ev.dt);
        if (ev.kind == OP_IMU) begin
            // Dead reckoning only runs once a GPS fix has set the state up.
            if (nav_init && dt != 0) begin
                nav_yaw = wrap_pi(nav_yaw + round_shift(m[0] * dt, 16));
                rotate_q30(nav_yaw <<< 14, c, s);
                an = round_shift(m[1] * round_shift(c, 14), 16);
                ae = round_shift(m[1] * round_shift(s, 14), 16);
                nav_vel[0] = clamp32(nav_vel[0] + round_shift(an * dt, 16));
                nav_vel[1] = clamp32(nav_vel[1] + round_shift(ae * dt, 16));
                for (int k = 0; k < 3; k++)
                    nav_pos[k] = clamp32(nav_pos[k] + round_shift(nav_vel[k] * dt, 16));
            end
        end else if (ev.kind == OP_GPS && ev.valid_flag) begin
            if (!nav_init) begin
                // The first fix loads the state directly.
                for (int k = 0; k < 3; k++) begin
                    nav_pos[k] = m[k];
                    nav_vel[k] = m[k + 3];
                end
                nav_yaw = is_moving(m[3], m[4]) ? track_of(m[3], m[4]) : 0;
                nav_init = 1'b1;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    nav_pos[k] = clamp32(nav_pos[k] + round_shift(k_pos * (m[k] - nav_pos[k]), 16));
                    nav_vel[k] = clamp32(nav_vel[k]
                                         + round_shift(k_vel * (m[k + 3] - nav_vel[k]), 16));
                end
                // A receiver standing still gives no usable track, so yaw is left alone.
                if (is_moving(m[3], m[4])) begin
                    err = wrap_pi(track_of(m[3], m[4]) - nav_yaw);
                    nav_yaw = wrap_pi(nav_yaw + round_shift(k_head * err, 16));
                end
            end
        end else if (ev.kind == OP_BARO && ev.valid_flag) begin
            // Altitude is up, the state is down; this blend also runs before init.
            nav_pos[2] = clamp32(round_shift((UNITY_GAIN - k_alt) * nav_pos[2]
                                             + k_alt * (-m[0]), 16));
        end
        rotate_q30((nav_yaw <<< 14) >>> 1, c, s);
        r.pn = nav_pos[0][31:0];
        r.pe = nav_pos[1][31:0];
        r.pd = nav_pos[2][31:0];
        r.vn = nav_vel[0][31:0];
        r.ve = nav_vel[1][31:0];
        r.vd = nav_vel[2][31:0];
        r.hd = nav_yaw[HEAD_W-1:0];
        c = round_shift(c, 14);
        s = round_shift(s, 14);
        r.qs = c[QUAT_W-1:0];
        r.qz = s[QUAT_W-1:0];
        r.init = nav_init;
        return r;
    endfunction

    // Random Q16.16 value, mostly of moderate size so the estimate does not pin at the rails.
    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(0, 2 << $urandom_range(4, 24)))
                            - $signed(1 << $urandom_range(4, 24));
        endcase
    endfunction

    function automatic sensor_event_t make_event(logic [1:0] kind, logic vf, logic [15:0] dt,
                                                 logic signed [31:0] a, logic signed [31:0] b,
                                                 logic signed [31:0] c, logic signed [31:0] d,
                                                 logic signed [31:0] e, logic signed [31:0] f);
        sensor_event_t ev;
        ev.kind = kind;
        ev.valid_flag = vf;
        ev.dt = dt;
        ev.ma = a;
        ev.mb = b;
        ev.mc = c;
        ev.md = d;
        ev.me = e;
        ev.mf = f;
        return ev;
    endfunction

    function automatic sensor_event_t rand_event();
        sensor_event_t ev;
        int pick;
        pick = $urandom_range(99);
        ev = make_event(OP_IMU, $urandom_range(1), $urandom, rand_q16(), rand_q16(),
                        rand_q16(), rand_q16(), rand_q16(), rand_q16());
        if (pick < 45) begin
            ev.kind = OP_IMU;
            case ($urandom_range(5))
                0: ev.dt = '0;
                1: ev.dt = $urandom_range(1, 64);
                2: ev.dt = $urandom;
                default: ev.dt = $urandom_range(1, 4000);
            endcase
        end else if (pick < 77) begin
            ev.kind = OP_GPS;
            ev.valid_flag = ($urandom_range(99) < 85);
            case ($urandom_range(4))
                0: begin
                    // Velocity within the standing-still band.
                    ev.md = $signed($urandom_range(0, 2 * STILL_VEL)) - STILL_VEL;
                    ev.me = $signed($urandom_range(0, 2 * STILL_VEL)) - STILL_VEL;
                end
                1: begin
                    // Heading due south sits on the plus minus pi seam.
                    ev.md = -$signed($urandom_range(100, 1 << 20));
                    ev.me = $urandom_range(1) ? 0 : $signed($urandom_range(0, 3)) - 1;
                end
                default: ;
            endcase
        end else if (pick < 94) begin
            ev.kind = OP_BARO;
            ev.valid_flag = ($urandom_range(99) < 85);
        end else begin
            ev.kind = OP_UNUSED;
        end
        return ev;
    endfunction

    task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_GAIN_POS:  k_pos = val;
            CFG_GAIN_VEL:  k_vel = val;
            CFG_GAIN_HEAD: k_head = val;
            CFG_GAIN_ALT:  k_alt = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_gains(logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gv,
                             logic [GAIN_W-1:0] gh, logic [GAIN_W-1:0] ga);
        write_gain(CFG_GAIN_POS, gp);
        write_gain(CFG_GAIN_VEL, gv);
        write_gain(CFG_GAIN_HEAD, gh);
        write_gain(CFG_GAIN_ALT, ga);
    endtask

    // Waits until every queued event has been taken and every report has come back.
    task automatic drain();
        while (event_fifo.size() != 0 || item_valid || report_fifo.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    // Sender: a new event goes out only after the previous one was taken, and
    // valid stays up with a stable payload until the filter accepts it.
    always @(negedge clk) begin
        if (rst_n && (!item_valid || bus_taken)) begin
            if (event_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                on_bus = event_fifo.pop_front();
                item_valid <= 1'b1;
                op <= on_bus.kind;
                meas_valid <= on_bus.valid_flag;
                step_time <= on_bus.dt;
                meas_a <= on_bus.ma;
                meas_b <= on_bus.mb;
                meas_c <= on_bus.mc;
                meas_d <= on_bus.md;
                meas_e <= on_bus.me;
                meas_f <= on_bus.mf;
            end else begin
                item_valid <= 1'b0;
            end
        end
        bus_taken = 1'b0;
        if (rst_n)
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on every accepted event, check every accepted report.
    always @(posedge clk) begin
        nav_report_t want;
        if (rst_n && item_valid && item_ready) begin
            report_fifo.push_back(advance_nav(on_bus));
            bus_taken = 1'b1;
        end
        if (rst_n && result_valid && result_ready) begin
            if (report_fifo.size() == 0) begin
                $display("%0t: unexpected result transaction", $time);
                failed = 1'b1;
            end else begin
                want = report_fifo.pop_front();
                if ({want.pn, want.pe, want.pd, want.vn, want.ve, want.vd, want.hd,
                     want.qs, want.qz, want.init} !==
                    {pos_north, pos_east, pos_down, vel_north, vel_east, vel_down,
                     heading, quat_scalar, quat_z, is_initialised}) begin
                    $display("%0t: mismatch expected pos %0d %0d %0d vel %0d %0d %0d hd %0d q %0d %0d i %0b",
                             $time, want.pn, want.pe, want.pd, want.vn, want.ve, want.vd,
                             $signed(want.hd), $signed(want.qs), $signed(want.qz), want.init);
                    $display("%0t:          actual pos %0d %0d %0d vel %0d %0d %0d hd %0d q %0d %0d i %0b",
                             $time, pos_north, pos_east, pos_down, vel_north, vel_east,
                             vel_down, heading, quat_scalar, quat_z, is_initialised);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        logic [GAIN_W-1:0] gain_sets[8][4];
        for (int k = 0; k < 3; k++) begin
            nav_pos[k] = 0;
            nav_vel[k] = 0;
        end
        nav_yaw = 0;
        nav_init = 1'b0;
        k_pos = 6554;
        k_vel = 6554;
        k_head = 6554;
        k_alt = 6554;
        // Zero, unity, the largest register value (above unity), the reset value, then random mixes.
        gain_sets = '{'{0, 0, 0, 0}, '{65536, 65536, 65536, 65536},
                      '{131071, 131071, 131071, 131071}, '{6554, 6554, 6554, 6554},
                      '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}};
        for (int p = 4; p < 8; p++)
            for (int g = 0; g < 4; g++)
                gain_sets[p][g] = $urandom_range(0, 70000);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under reset gains: events before init, the first fix, then edges.
        event_fifo.push_back(make_event(OP_IMU, 1, 16'hFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                        0, 0, 0, 0));
        event_fifo.push_back(make_event(OP_BARO, 0, 0, 32'sh0A0000, 0, 0, 0, 0, 0));
        event_fifo.push_back(make_event(OP_BARO, 1, 0, 32'sh0A0000, 0, 0, 0, 0, 0));
        event_fifo.push_back(make_event(OP_GPS, 0, 0, 5, 6, 7, 8, 9, 10));
        event_fifo.push_back(make_event(OP_UNUSED, 1, 16'hFFFF, -1, -1, -1, -1, -1, -1));
        event_fifo.push_back(make_event(OP_GPS, 1, 0, 32'sh10000, -32'sh20000, 32'sh30000,
                                        66, -66, 32'sh8000));
        event_fifo.push_back(make_event(OP_IMU, 1, 0, 32'sh10000, 32'sh10000, 0, 0, 0, 0));
        event_fifo.push_back(make_event(OP_IMU, 0, 16'hFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                                        0, 0, 0, 0));
        event_fifo.push_back(make_event(OP_IMU, 1, 16'h0001, 32'sh80000000, 32'sh7FFFFFFF,
                                        0, 0, 0, 0));
        event_fifo.push_back(make_event(OP_GPS, 1, 0, 32'sh7FFFFFFF, 32'sh80000000,
                                        32'sh7FFFFFFF, -32'sh40000, 0, 32'sh80000000));
        event_fifo.push_back(make_event(OP_GPS, 1, 0, 32'sh80000000, 32'sh7FFFFFFF,
                                        32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                                        32'sh7FFFFFFF));
        event_fifo.push_back(make_event(OP_GPS, 1, 0, 0, 0, 0, -32'sh10000, -1, 0));
        event_fifo.push_back(make_event(OP_GPS, 1, 0, 0, 0, 0, 67, 0, 0));
        event_fifo.push_back(make_event(OP_BARO, 1, 0, 32'sh80000000, 0, 0, 0, 0, 0));
        event_fifo.push_back(make_event(OP_BARO, 1, 0, 32'sh7FFFFFFF, 0, 0, 0, 0, 0));
        event_fifo.push_back(make_event(OP_IMU, 1, 16'hFFFF, 32'sh30000, 32'sh7FFFFFFF,
                                        0, 0, 0, 0));
        event_fifo.push_back(make_event(OP_IMU, 0, 16'h8000, -32'sh60000, 32'sh80000000,
                                        0, 0, 0, 0));
        drain();

        // Random phases, each with its own gains and one of four idling patterns.
        for (int p = 0; p < 8; p++) begin
            set_gains(gain_sets[p][0], gain_sets[p][1], gain_sets[p][2], gain_sets[p][3]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int n = 0; n < 210; n++)
                event_fifo.push_back(rand_event());
            drain();
        end

        if (!failed)
            $display("PASS yaw_complementary_nav_filter");
        else
            $display("FAIL yaw_complementary_nav_filter");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #40_000_000;
        $display("FAIL yaw_complementary_nav_filter");
        $finish;
    end

endmodule
